@@ rtl/ostb_pkg.sv @@
// ----------------------------------------------------------------------------
// ostb_pkg
// Shared types and constants of the one-shot timer bank.
// ----------------------------------------------------------------------------
package ostb_pkg;

    // Fixed field widths of the input and result ports
    localparam int HANDLER_W   = 8;
    localparam int SLOT_FLD_W  = 3;
    localparam int OUT_TICK_W  = 32;
    localparam int SLOW_W      = 32;
    localparam int DELAY_W     = 32;

    // Every fourth tick is passed on to the legacy handler
    localparam logic [1:0] TICK_PHASE_MASK = 2'b11;

    // Input item kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // Shared adder operations
    typedef enum logic [1:0] {
        ALU_INC,
        ALU_ADD,
        ALU_GE
    } ostb_alu_op_t;

    // Control strobes from the sequencer to the slot store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic set_busy;
        logic clr_busy;
    } ostb_store_ctl_t;

endpackage

@@ rtl/ostb_alu.sv @@
// ----------------------------------------------------------------------------
// ostb_alu
// Shared tick adder: increment, deadline add and unsigned compare.
// ----------------------------------------------------------------------------
module ostb_alu
    import ostb_pkg::*;
#(
    parameter int TICK_BITS = 32
)
(
    input  ostb_alu_op_t         op,
    input  logic [TICK_BITS-1:0] a,
    input  logic [TICK_BITS-1:0] b,
    output logic [TICK_BITS-1:0] sum,
    output logic                 a_ge_b
);

    logic [TICK_BITS-1:0] b_eff;
    logic                 cin;
    logic [TICK_BITS:0]   total;

    // Pick the second operand and carry in for the operation
    always_comb
    begin
        case (op)
            ALU_INC:
            begin
                b_eff = '0;
                cin   = 1'b1;
            end
            ALU_ADD:
            begin
                b_eff = b;
                cin   = 1'b0;
            end
            ALU_GE:
            begin
                b_eff = ~b;
                cin   = 1'b1;
            end
            default:
            begin
                b_eff = '0;
                cin   = 1'b0;
            end
        endcase
    end

    // One adder; carry out of a - b means a >= b
    assign total  = {1'b0, a} + {1'b0, b_eff} + (TICK_BITS+1)'(cin);
    assign sum    = total[TICK_BITS-1:0];
    assign a_ge_b = total[TICK_BITS];

endmodule

@@ rtl/ostb_slot_store.sv @@
// ----------------------------------------------------------------------------
// ostb_slot_store
// Slot deadline and handler memory with registered read, plus busy flags.
// ----------------------------------------------------------------------------
module ostb_slot_store
    import ostb_pkg::*;
#(
    parameter int SLOT_COUNT = 8,
    parameter int TICK_BITS  = 32,
    parameter int IDX_W      = 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ostb_store_ctl_t      ctl,
    input  logic [IDX_W-1:0]     idx,
    input  logic [TICK_BITS-1:0] wr_deadline,
    input  logic [HANDLER_W-1:0] wr_handler,
    output logic                 busy,
    output logic [TICK_BITS-1:0] rd_deadline,
    output logic [HANDLER_W-1:0] rd_handler
);

    logic [TICK_BITS-1:0] deadline_mem [SLOT_COUNT];
    logic [HANDLER_W-1:0] handler_mem  [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] busy_reg;

    // Write and read the slot memory
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            deadline_mem[idx] <= wr_deadline;
            handler_mem[idx]  <= wr_handler;
        end
        if (ctl.rd_en)
        begin
            rd_deadline <= deadline_mem[idx];
            rd_handler  <= handler_mem[idx];
        end
    end

    // Mark slots taken and freed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else
        begin
            if (ctl.set_busy)
            begin
                busy_reg[idx] <= 1'b1;
            end
            else if (ctl.clr_busy)
            begin
                busy_reg[idx] <= 1'b0;
            end
        end
    end

    assign busy = busy_reg[idx];

endmodule

@@ rtl/one_shot_timer_bank_top.sv @@
// ----------------------------------------------------------------------------
// one_shot_timer_bank_top
// Bank of one-shot timers scanned slot by slot by a small sequencer.
// ----------------------------------------------------------------------------
// Channel | Handshake            | Payload
// input   | in_valid / in_stall  | req_type, delay_ticks, handler_tag
// result  | out_valid / out_stall| fired .. slow_count, last marks end of item
// config  | cfg_valid / cfg_ready| cfg_data -> time_critical_enable
//
// A start scans for the lowest free slot, one slot a cycle, then pushes its
// result. A tick increments the counter on the shared adder, then visits each
// slot in turn, skipping free ones; a busy slot gets a registered memory
// read, then a compare on the same adder; the last result ends the tick.
// Output stalls hold the sequencer. Reset frees all slots and clears both
// counters and the enable; the slot memory itself is not cleared.
// ----------------------------------------------------------------------------
module one_shot_timer_bank_top
    import ostb_pkg::*;
#(
    parameter int SLOT_COUNT = 8,
    parameter int TICK_BITS  = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input items
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic [DELAY_W-1:0]    delay_ticks,
    input  logic [HANDLER_W-1:0]  handler_tag,
    // result items
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  fired,
    output logic [SLOT_FLD_W-1:0] fired_slot,
    output logic [HANDLER_W-1:0]  fired_handler,
    output logic                  last,
    output logic                  chain_legacy,
    output logic                  critical_hook,
    output logic                  start_ok,
    output logic [SLOT_FLD_W-1:0] start_slot,
    output logic [OUT_TICK_W-1:0] current_tick,
    output logic [SLOW_W-1:0]     slow_count,
    // configuration
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START_SCAN,
        ST_START_PUSH,
        ST_TICK_INC,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_TICK_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [DELAY_W-1:0]     delay_reg, delay_next;
    logic [HANDLER_W-1:0]   tag_reg, tag_next;
    logic [TICK_BITS-1:0]   fast_reg, fast_next;
    logic [SLOW_W-1:0]      slow_reg, slow_next;
    logic                   tce_reg, tce_next;
    logic                   chain_reg, chain_next;
    logic                   crit_reg, crit_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]       pend_slot_reg, pend_slot_next;
    logic [HANDLER_W-1:0]   pend_handler_reg, pend_handler_next;
    logic                   res_ok_reg, res_ok_next;
    logic [IDX_W-1:0]       res_slot_reg, res_slot_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_fired_reg, out_fired_next;
    logic [SLOT_FLD_W-1:0]  out_fslot_reg, out_fslot_next;
    logic [HANDLER_W-1:0]   out_fhandler_reg, out_fhandler_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_chain_reg, out_chain_next;
    logic                   out_crit_reg, out_crit_next;
    logic                   out_sok_reg, out_sok_next;
    logic [SLOT_FLD_W-1:0]  out_sslot_reg, out_sslot_next;
    logic [OUT_TICK_W-1:0]  out_tick_reg, out_tick_next;
    logic [SLOW_W-1:0]      out_slow_reg, out_slow_next;

    logic                   in_accept;
    logic                   out_free;
    ostb_alu_op_t           alu_op;
    logic [TICK_BITS-1:0]   alu_b;
    logic [TICK_BITS-1:0]   alu_sum;
    logic                   alu_ge;
    logic [TICK_BITS-1:0]   delay_ext;
    ostb_store_ctl_t        store_ctl;
    logic                   slot_busy;
    logic [TICK_BITS-1:0]   rd_deadline;
    logic [HANDLER_W-1:0]   rd_handler;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign delay_ext = TICK_BITS'({{TICK_BITS{1'b0}}, delay_reg});

    // Shared adder
    ostb_alu #(
        .TICK_BITS (TICK_BITS)
    ) u_alu (
        .op     (alu_op),
        .a      (fast_reg),
        .b      (alu_b),
        .sum    (alu_sum),
        .a_ge_b (alu_ge)
    );

    // Slot storage
    ostb_slot_store #(
        .SLOT_COUNT (SLOT_COUNT),
        .TICK_BITS  (TICK_BITS),
        .IDX_W      (IDX_W)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (store_ctl),
        .idx         (idx_reg),
        .wr_deadline (alu_sum),
        .wr_handler  (tag_reg),
        .busy        (slot_busy),
        .rd_deadline (rd_deadline),
        .rd_handler  (rd_handler)
    );

    // Select the adder operation for the current step
    always_comb
    begin
        case (state_reg)
            ST_START_SCAN:
            begin
                alu_op = ALU_ADD;
                alu_b  = delay_ext;
            end
            ST_SCAN_CMP:
            begin
                alu_op = ALU_GE;
                alu_b  = rd_deadline;
            end
            default:
            begin
                alu_op = ALU_INC;
                alu_b  = '0;
            end
        endcase
    end

    // Sequencer and output register next values
    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        delay_next        = delay_reg;
        tag_next          = tag_reg;
        fast_next         = fast_reg;
        slow_next         = slow_reg;
        tce_next          = tce_reg;
        chain_next        = chain_reg;
        crit_next         = crit_reg;
        pend_valid_next   = pend_valid_reg;
        pend_slot_next    = pend_slot_reg;
        pend_handler_next = pend_handler_reg;
        res_ok_next       = res_ok_reg;
        res_slot_next     = res_slot_reg;
        store_ctl         = '0;

        // drop the output once taken
        out_valid_next    = out_valid_reg && out_stall;
        out_fired_next    = out_fired_reg;
        out_fslot_next    = out_fslot_reg;
        out_fhandler_next = out_fhandler_reg;
        out_last_next     = out_last_reg;
        out_chain_next    = out_chain_reg;
        out_crit_next     = out_crit_reg;
        out_sok_next      = out_sok_reg;
        out_sslot_next    = out_sslot_reg;
        out_tick_next     = OUT_TICK_W'({{OUT_TICK_W{1'b0}}, fast_reg});
        out_slow_next     = slow_reg;
        if (out_valid_reg && out_stall)
        begin
            out_tick_next = out_tick_reg;
            out_slow_next = out_slow_reg;
        end

        if (cfg_valid)
        begin
            tce_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    delay_next = delay_ticks;
                    tag_next   = handler_tag;
                    idx_next   = '0;
                    if (req_type == REQ_START)
                    begin
                        state_next = ST_START_SCAN;
                    end
                    else
                    begin
                        state_next = ST_TICK_INC;
                    end
                end
            end

            // look for the lowest free slot
            ST_START_SCAN:
            begin
                if (!slot_busy)
                begin
                    store_ctl.wr_en    = 1'b1;
                    store_ctl.set_busy = 1'b1;
                    res_ok_next        = 1'b1;
                    res_slot_next      = idx_reg;
                    state_next         = ST_START_PUSH;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    res_ok_next   = 1'b0;
                    res_slot_next = '0;
                    state_next    = ST_START_PUSH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_START_PUSH:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_fired_next    = 1'b0;
                    out_fslot_next    = '0;
                    out_fhandler_next = '0;
                    out_last_next     = 1'b1;
                    out_chain_next    = 1'b0;
                    out_crit_next     = 1'b0;
                    out_sok_next      = res_ok_reg;
                    out_sslot_next    = SLOT_FLD_W'({{SLOT_FLD_W{1'b0}}, res_slot_reg});
                    state_next        = ST_IDLE;
                end
            end

            // advance the tick counter
            ST_TICK_INC:
            begin
                fast_next       = alu_sum;
                chain_next      = (alu_sum[1:0] & TICK_PHASE_MASK) == 2'b00;
                crit_next       = tce_reg;
                pend_valid_next = 1'b0;
                if ((alu_sum[1:0] & TICK_PHASE_MASK) == 2'b00)
                begin
                    slow_next = slow_reg + 1'b1;
                end
                state_next = ST_SCAN_RD;
            end

            // read busy slots, skip free ones
            ST_SCAN_RD:
            begin
                if (slot_busy)
                begin
                    store_ctl.rd_en = 1'b1;
                    state_next      = ST_SCAN_CMP;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_TICK_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // compare the deadline, hold one hit back to know the last one
            ST_SCAN_CMP:
            begin
                if (!alu_ge || !pend_valid_reg || out_free)
                begin
                    if (alu_ge)
                    begin
                        store_ctl.clr_busy = 1'b1;
                        if (pend_valid_reg)
                        begin
                            out_valid_next    = 1'b1;
                            out_fired_next    = 1'b1;
                            out_fslot_next    =
                                SLOT_FLD_W'({{SLOT_FLD_W{1'b0}}, pend_slot_reg});
                            out_fhandler_next = pend_handler_reg;
                            out_last_next     = 1'b0;
                            out_chain_next    = chain_reg;
                            out_crit_next     = crit_reg;
                            out_sok_next      = 1'b0;
                            out_sslot_next    = '0;
                        end
                        pend_valid_next   = 1'b1;
                        pend_slot_next    = idx_reg;
                        pend_handler_next = rd_handler;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_TICK_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SCAN_RD;
                    end
                end
            end

            // send the final result of the tick
            ST_TICK_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_fired_next    = pend_valid_reg;
                    out_fslot_next    = pend_valid_reg ?
                        SLOT_FLD_W'({{SLOT_FLD_W{1'b0}}, pend_slot_reg}) : '0;
                    out_fhandler_next = pend_valid_reg ? pend_handler_reg : '0;
                    out_last_next     = 1'b1;
                    out_chain_next    = chain_reg;
                    out_crit_next     = crit_reg;
                    out_sok_next      = 1'b0;
                    out_sslot_next    = '0;
                    pend_valid_next   = 1'b0;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fast_reg       <= '0;
            slow_reg       <= '0;
            tce_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fast_reg       <= fast_next;
            slow_reg       <= slow_next;
            tce_reg        <= tce_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg          <= idx_next;
        delay_reg        <= delay_next;
        tag_reg          <= tag_next;
        chain_reg        <= chain_next;
        crit_reg         <= crit_next;
        pend_slot_reg    <= pend_slot_next;
        pend_handler_reg <= pend_handler_next;
        res_ok_reg       <= res_ok_next;
        res_slot_reg     <= res_slot_next;
        out_fired_reg    <= out_fired_next;
        out_fslot_reg    <= out_fslot_next;
        out_fhandler_reg <= out_fhandler_next;
        out_last_reg     <= out_last_next;
        out_chain_reg    <= out_chain_next;
        out_crit_reg     <= out_crit_next;
        out_sok_reg      <= out_sok_next;
        out_sslot_reg    <= out_sslot_next;
        out_tick_reg     <= out_tick_next;
        out_slow_reg     <= out_slow_next;
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign fired         = out_fired_reg;
    assign fired_slot    = out_fslot_reg;
    assign fired_handler = out_fhandler_reg;
    assign last          = out_last_reg;
    assign chain_legacy  = out_chain_reg;
    assign critical_hook = out_crit_reg;
    assign start_ok      = out_sok_reg;
    assign start_slot    = out_sslot_reg;
    assign current_tick  = out_tick_reg;
    assign slow_count    = out_slow_reg;

    // Block stays busy after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("input taken while an item is still in progress");

    // A held-back hit exists only during a tick scan
    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == ST_SCAN_RD || state_reg == ST_SCAN_CMP ||
                            state_reg == ST_TICK_DONE))
        else $error("pending hit outside a tick scan");

    // A fired result never reports a start
    a_fired_not_start: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fired) |-> (!start_ok && start_slot == '0))
        else $error("fired result carries start fields");

    // The tick counter moves only in the increment step
    a_fast_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(fast_reg) |-> $past(state_reg == ST_TICK_INC))
        else $error("tick counter changed outside a tick");

endmodule
